### rtl/multi_key_press_event_scanner_top_defines.svh
// Assertion macros used by the key scanner checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MULTI_KEY_PRESS_EVENT_SCANNER_TOP_DEFINES_SVH
`define MULTI_KEY_PRESS_EVENT_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MKPES_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MKPES_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mkpes_pkg.sv
// Package for the multi-key press event scanner: widths, mode and event codes,
// and the structs passed between lanes, merge stage and top level. No dependencies.
package mkpes_pkg;

  localparam int NUM_KEYS  = 16;
  localparam int TICK_W    = 32;
  localparam int PINS_W    = 16;
  localparam int THR_W     = 16;
  localparam int KCNT_W    = 5;
  localparam int KEY_IDX_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [2:0] {
    MODE_RELEASE  = 3'd0,
    MODE_DEBOUNCE = 3'd1,
    MODE_PRESSED  = 3'd2,
    MODE_LONG     = 3'd3,
    MODE_REPEAT   = 3'd4
  } key_mode_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_PRESS        = 3'd1,
    EV_RELEASE      = 3'd2,
    EV_LONG         = 3'd3,
    EV_LONG_RELEASE = 3'd4,
    EV_REPEAT       = 3'd5
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE     = 3'd0,
    REG_LONG_PRESS   = 3'd1,
    REG_REPEAT_START = 3'd2,
    REG_REPEAT_INTV  = 3'd3,
    REG_KEY_COUNT    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0] settle_ticks;
    logic [THR_W-1:0] hold_ticks;
    logic [THR_W-1:0] repeat_start_time;
    logic [THR_W-1:0] repeat_interval;
  } thr_cfg_t;

  typedef struct packed {
    event_t                 event_res;
    logic [KEY_IDX_W-1:0]   key_index;
  } scan_res_t;

endpackage

### rtl/mkpes_if.sv
// Valid/ready channel interfaces for poll requests, scan results and register writes.
// Depends on mkpes_pkg.
interface mkpes_in_if;
  import mkpes_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] tick;
  logic [PINS_W-1:0] pins;
  modport source (output valid, output tick, output pins, input ready);
  modport sink (input valid, input tick, input pins, output ready);
endinterface

interface mkpes_out_if;
  import mkpes_pkg::*;
  logic                 valid;
  logic                 ready;
  event_t               event_res;
  logic [KEY_IDX_W-1:0] key_index;
  modport source (output valid, output event_res, output key_index, input ready);
  modport sink (input valid, input event_res, input key_index, output ready);
endinterface

interface mkpes_cfg_if;
  import mkpes_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/mkpes_lane.sv
// One key lane: mode, press mark and repeat mark registers plus the next-state logic.
// Depends on mkpes_pkg.
module mkpes_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mkpes_pkg::thr_cfg_t         thr,
  input  logic [mkpes_pkg::TICK_W-1:0] tick,
  input  logic                        down,
  input  logic                        commit,
  output mkpes_pkg::event_t           ev
);
  import mkpes_pkg::*;

  key_mode_t         mode_r, mode_nxt;
  logic [TICK_W-1:0] mark_r, mark_nxt;
  logic [TICK_W-1:0] rep_r, rep_nxt;
  logic [TICK_W-1:0] base;
  logic [TICK_W-1:0] elapsed;
  logic [THR_W-1:0]  limit;
  logic              reached;

  always_comb begin
    base    = (mode_r == MODE_REPEAT) ? rep_r : mark_r;
    elapsed = tick - base;
    case (mode_r)
      MODE_DEBOUNCE: limit = thr.settle_ticks;
      MODE_PRESSED:  limit = thr.hold_ticks;
      MODE_LONG:     limit = thr.repeat_start_time;
      default:       limit = thr.repeat_interval;
    endcase
    reached = elapsed >= {{(TICK_W-THR_W){1'b0}}, limit};
  end

  always_comb begin
    mode_nxt = mode_r;
    mark_nxt = mark_r;
    rep_nxt  = rep_r;
    ev       = EV_NONE;
    case (mode_r)
      MODE_RELEASE: begin
        if (down) begin
          mode_nxt = MODE_DEBOUNCE;
          mark_nxt = tick;
        end
      end
      MODE_DEBOUNCE: begin
        if (!down) begin
          mode_nxt = MODE_RELEASE;
        end else if (reached) begin
          mode_nxt = MODE_PRESSED;
          mark_nxt = tick;
          ev       = EV_PRESS;
        end
      end
      MODE_PRESSED: begin
        if (!down) begin
          mode_nxt = MODE_RELEASE;
          ev       = EV_RELEASE;
        end else if (reached) begin
          mode_nxt = MODE_LONG;
          mark_nxt = tick;
          ev       = EV_LONG;
        end
      end
      MODE_LONG: begin
        if (!down) begin
          mode_nxt = MODE_RELEASE;
          ev       = EV_LONG_RELEASE;
        end else if (reached) begin
          mode_nxt = MODE_REPEAT;
          rep_nxt  = tick;
        end
      end
      MODE_REPEAT: begin
        if (!down) begin
          mode_nxt = MODE_RELEASE;
        end else if (reached) begin
          rep_nxt = tick;
          ev      = EV_REPEAT;
        end
      end
      default: begin
        mode_nxt = MODE_RELEASE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RELEASE;
      mark_r <= '0;
      rep_r  <= '0;
    end else if (commit) begin
      mode_r <= mode_nxt;
      mark_r <= mark_nxt;
      rep_r  <= rep_nxt;
    end
  end

endmodule

### rtl/mkpes_merge.sv
// Merge stage: picks the lowest scanned key with an event and decides which lanes update.
// Depends on mkpes_pkg.
module mkpes_merge (
  input  mkpes_pkg::event_t [mkpes_pkg::NUM_KEYS-1:0] lane_ev,
  input  logic [mkpes_pkg::KCNT_W-1:0]                key_count,
  output logic [mkpes_pkg::NUM_KEYS-1:0]              lane_commit,
  output mkpes_pkg::scan_res_t                        res
);
  import mkpes_pkg::*;

  logic [KCNT_W-1:0] scan_n;
  logic              seen;

  assign scan_n = (key_count > KCNT_W'(NUM_KEYS)) ? KCNT_W'(NUM_KEYS) : key_count;

  always_comb begin
    seen          = 1'b0;
    lane_commit   = '0;
    res.event_res = EV_NONE;
    res.key_index = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if ((KCNT_W'(k) < scan_n) && !seen) begin
        lane_commit[k] = 1'b1;
        if (lane_ev[k] != EV_NONE) begin
          seen          = 1'b1;
          res.event_res = lane_ev[k];
          res.key_index = KEY_IDX_W'(k);
        end
      end
    end
  end

endmodule

### rtl/multi_key_press_event_scanner_top.sv
// A poll request's result is registered and shown in the cycle after the request is accepted.
// Throughput: one poll per cycle while results are taken; a held result stalls input.
// The rate holds because the per-key lanes and the priority merge are combinational.
// Reset (synchronous, rst_n low): all keys in release, marks zero, registers at defaults.
// Depends on mkpes_pkg, the channel interfaces, mkpes_lane and mkpes_merge.
module multi_key_press_event_scanner_top (
  input  logic              clk,
  input  logic              rst_n,
  mkpes_in_if.sink          in_ch,
  mkpes_out_if.source       out_ch,
  mkpes_cfg_if.sink         cfg_ch
);
  import mkpes_pkg::*;

  thr_cfg_t                thr_r;
  logic [KCNT_W-1:0]       key_count_r;
  event_t [NUM_KEYS-1:0]   lane_ev;
  logic [NUM_KEYS-1:0]     lane_commit;
  scan_res_t               scan_res;
  scan_res_t               out_res_r;
  logic                    out_valid_r;
  logic                    in_take;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.settle_ticks      <= THR_W'(20);
      thr_r.hold_ticks        <= THR_W'(1000);
      thr_r.repeat_start_time <= THR_W'(500);
      thr_r.repeat_interval   <= THR_W'(100);
      key_count_r             <= KCNT_W'(8);
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_DEBOUNCE:     thr_r.settle_ticks      <= cfg_ch.data;
        REG_LONG_PRESS:   thr_r.hold_ticks        <= cfg_ch.data;
        REG_REPEAT_START: thr_r.repeat_start_time <= cfg_ch.data;
        REG_REPEAT_INTV:  thr_r.repeat_interval   <= cfg_ch.data;
        REG_KEY_COUNT:    key_count_r             <= cfg_ch.data[KCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    mkpes_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .thr    (thr_r),
      .tick   (in_ch.tick),
      .down   (!in_ch.pins[k]),
      .commit (in_take && lane_commit[k]),
      .ev     (lane_ev[k])
    );
  end

  mkpes_merge u_merge (
    .lane_ev     (lane_ev),
    .key_count   (key_count_r),
    .lane_commit (lane_commit),
    .res         (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_res_r <= scan_res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.event_res = out_res_r.event_res;
  assign out_ch.key_index = out_res_r.key_index;

endmodule

### rtl/mkpes_checker.sv
// Port-level checker for the key scanner top level, attached by the bind below.
// Depends on mkpes_pkg and multi_key_press_event_scanner_top_defines.svh.
`include "multi_key_press_event_scanner_top_defines.svh"

module mkpes_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      out_event_res,
  input logic [mkpes_pkg::KEY_IDX_W-1:0] out_key_index
);
  import mkpes_pkg::*;

  `MKPES_ASSERT_NEXT(a_accept_gives_result, in_valid && in_ready, out_valid, "accepted request gave no result")
  `MKPES_ASSERT_SAME(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "input taken while result is held")
  `MKPES_ASSERT_SAME(a_none_has_zero_index, out_valid && (out_event_res == EV_NONE), out_key_index == '0, "no-event result with nonzero key index")
  `MKPES_ASSERT_NEXT(a_held_result_stable, out_valid && !out_ready, out_valid && $stable(out_event_res) && $stable(out_key_index), "stalled result changed")

endmodule

bind multi_key_press_event_scanner_top mkpes_checker u_mkpes_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_event_res (out_ch.event_res),
  .out_key_index (out_ch.key_index)
);

### test/tb_multi_key_press_event_scanner_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for multi_key_press_event_scanner_top: a directed table of polls
// and register writes, then random phases; each result is checked against the table or a key predictor.
// Depends on mkpes_pkg, the channel interfaces and the scanner RTL.
module tb_multi_key_press_event_scanner_top;
  import mkpes_pkg::*;

  typedef enum logic {ROW_POLL, ROW_WRITE} row_kind_t;
  typedef enum logic [1:0] {PH_RANDOM, PH_ZERO, PH_MAX} phase_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [TICK_W-1:0]    tick;
    logic [PINS_W-1:0]    pins;
    bit                   typed;
    scan_res_t            res;
    cfg_reg_t             reg_sel;
    logic [CFG_DAT_W-1:0] data;
  } row_t;

  localparam int STALL_LIMIT = 1000;
  localparam int MAX_SHOWN   = 10;

  logic clk;
  logic rst_n;

  mkpes_in_if  poll_ch ();
  mkpes_out_if scan_ch ();
  mkpes_cfg_if reg_ch ();

  multi_key_press_event_scanner_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (poll_ch),
    .out_ch (scan_ch),
    .cfg_ch (reg_ch)
  );

  thr_cfg_t          thr;
  logic [KCNT_W-1:0] key_count;
  key_mode_t         lane_mode [NUM_KEYS];
  logic [TICK_W-1:0] lane_mark [NUM_KEYS];
  logic [TICK_W-1:0] lane_rpt [NUM_KEYS];
  scan_res_t         expected_q [$];
  row_t              plan [$];
  int                mismatches;
  int                stall_cycles;
  int                src_idle_pct;
  int                snk_idle_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic scan_res_t scan_keys(logic [TICK_W-1:0] now, logic [PINS_W-1:0] pins);
    scan_res_t res;
    event_t    ev;
    int        n;
    logic      down;
    res.event_res = EV_NONE;
    res.key_index = '0;
    n = (key_count > NUM_KEYS) ? NUM_KEYS : int'(key_count);
    for (int k = 0; k < n; k++) begin
      down = ~pins[k];
      ev = EV_NONE;
      case (lane_mode[k])
        MODE_RELEASE: begin
          if (down) begin
            lane_mode[k] = MODE_DEBOUNCE;
            lane_mark[k] = now;
          end
        end
        MODE_DEBOUNCE: begin
          if (!down) begin
            lane_mode[k] = MODE_RELEASE;
          end else if (now - lane_mark[k] >= TICK_W'(thr.settle_ticks)) begin
            lane_mode[k] = MODE_PRESSED;
            lane_mark[k] = now;
            ev = EV_PRESS;
          end
        end
        MODE_PRESSED: begin
          if (!down) begin
            lane_mode[k] = MODE_RELEASE;
            ev = EV_RELEASE;
          end else if (now - lane_mark[k] >= TICK_W'(thr.hold_ticks)) begin
            lane_mode[k] = MODE_LONG;
            lane_mark[k] = now;
            ev = EV_LONG;
          end
        end
        MODE_LONG: begin
          if (!down) begin
            lane_mode[k] = MODE_RELEASE;
            ev = EV_LONG_RELEASE;
          end else if (now - lane_mark[k] >= TICK_W'(thr.repeat_start_time)) begin
            lane_mode[k] = MODE_REPEAT;
            lane_rpt[k] = now;
          end
        end
        MODE_REPEAT: begin
          if (!down) begin
            lane_mode[k] = MODE_RELEASE;
          end else if (now - lane_rpt[k] >= TICK_W'(thr.repeat_interval)) begin
            lane_rpt[k] = now;
            ev = EV_REPEAT;
          end
        end
        default: begin
          lane_mode[k] = MODE_RELEASE;
        end
      endcase
      if (ev != EV_NONE) begin
        res.event_res = ev;
        res.key_index = KEY_IDX_W'(k);
        break;
      end
    end
    return res;
  endfunction

  function automatic void apply_write(cfg_reg_t r, logic [CFG_DAT_W-1:0] d);
    case (r)
      REG_DEBOUNCE:     thr.settle_ticks = d;
      REG_LONG_PRESS:   thr.hold_ticks = d;
      REG_REPEAT_START: thr.repeat_start_time = d;
      REG_REPEAT_INTV:  thr.repeat_interval = d;
      REG_KEY_COUNT:    key_count = d[KCNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string what, scan_res_t want);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("%0t: %s: expected event %0d key %0d, got event %0d key %0d", $time, what,
               want.event_res, want.key_index, scan_ch.event_res, scan_ch.key_index);
    end
  endfunction

  always @(posedge clk) begin
    scan_res_t want;
    if (rst_n && reg_ch.valid && reg_ch.ready) begin
      apply_write(cfg_reg_t'(reg_ch.index), reg_ch.data);
    end
    if (rst_n && scan_ch.valid && scan_ch.ready) begin
      if (expected_q.size() == 0) begin
        note_mismatch("result with no request outstanding", '0);
      end else begin
        want = expected_q.pop_front();
        if (scan_ch.event_res !== want.event_res || scan_ch.key_index !== want.key_index) begin
          note_mismatch("scan result", want);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (poll_ch.valid && poll_ch.ready) || (scan_ch.valid && scan_ch.ready) ||
        (reg_ch.valid && reg_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin
    scan_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_poll(logic [TICK_W-1:0] t, logic [PINS_W-1:0] p, bit typed,
                           scan_res_t typed_res);
    scan_res_t res;
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      poll_ch.valid <= 1'b0;
      @(negedge clk);
    end
    poll_ch.valid <= 1'b1;
    poll_ch.tick  <= t;
    poll_ch.pins  <= p;
    do @(posedge clk); while (!(poll_ch.valid && poll_ch.ready));
    res = scan_keys(t, p);
    expected_q.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    poll_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DAT_W-1:0] d);
    wait_drain();
    @(negedge clk);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= r;
    reg_ch.data  <= d;
    do @(posedge clk); while (!(reg_ch.valid && reg_ch.ready));
    @(negedge clk);
    reg_ch.valid <= 1'b0;
  endtask

  function automatic row_t poll_row(logic [TICK_W-1:0] t, logic [PINS_W-1:0] p);
    row_t row;
    row.kind    = ROW_POLL;
    row.tick    = t;
    row.pins    = p;
    row.typed   = 1'b0;
    row.res     = '0;
    row.reg_sel = REG_DEBOUNCE;
    row.data    = '0;
    return row;
  endfunction

  function automatic row_t check_row(logic [TICK_W-1:0] t, logic [PINS_W-1:0] p, event_t ev,
                                     logic [KEY_IDX_W-1:0] k);
    row_t row;
    row = poll_row(t, p);
    row.typed         = 1'b1;
    row.res.event_res = ev;
    row.res.key_index = k;
    return row;
  endfunction

  function automatic row_t write_row(cfg_reg_t r, logic [CFG_DAT_W-1:0] d);
    row_t row;
    row = poll_row('0, '1);
    row.kind    = ROW_WRITE;
    row.reg_sel = r;
    row.data    = d;
    return row;
  endfunction

  function automatic logic [THR_W-1:0] pick_thr(int scale);
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 15) return '1;
    return THR_W'($urandom_range(scale));
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_count();
    logic [CFG_DAT_W-1:0] d;
    int                   r;
    d = CFG_DAT_W'($urandom());
    r = $urandom_range(99);
    if (r < 10) d[KCNT_W-1:0] = '0;
    else if (r < 25) d[KCNT_W-1:0] = KCNT_W'($urandom_range(31, 17));
    else d[KCNT_W-1:0] = KCNT_W'($urandom_range(16, 1));
    return d;
  endfunction

  task automatic run_phase(phase_kind_t kind, int n_items);
    int                scale;
    int                bit_sel;
    logic [TICK_W-1:0] now;
    logic [PINS_W-1:0] held;
    scale = $urandom_range(60, 4);
    case (kind)
      PH_ZERO: begin
        write_reg(REG_DEBOUNCE, '0);
        write_reg(REG_LONG_PRESS, '0);
        write_reg(REG_REPEAT_START, '0);
        write_reg(REG_REPEAT_INTV, '0);
        write_reg(REG_KEY_COUNT, 16'h0010);
      end
      PH_MAX: begin
        write_reg(REG_DEBOUNCE, '1);
        write_reg(REG_LONG_PRESS, '1);
        write_reg(REG_REPEAT_START, '1);
        write_reg(REG_REPEAT_INTV, '1);
        write_reg(REG_KEY_COUNT, 16'hFFF0);
      end
      default: begin
        write_reg(REG_DEBOUNCE, pick_thr(scale));
        write_reg(REG_LONG_PRESS, pick_thr(scale));
        write_reg(REG_REPEAT_START, pick_thr(scale));
        write_reg(REG_REPEAT_INTV, pick_thr(scale));
        write_reg(REG_KEY_COUNT, pick_count());
      end
    endcase
    now  = $urandom();
    held = '1;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_drain();
      if ($urandom_range(99) < 15) begin
        bit_sel = $urandom_range(PINS_W - 1);
        held[bit_sel] = ~held[bit_sel];
      end
      now += TICK_W'($urandom_range(scale / 4 + 1));
      if ($urandom_range(99) < 8) begin
        send_poll($urandom(), PINS_W'($urandom()), 1'b0, '0);
      end else begin
        send_poll(now, held, 1'b0, '0);
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    poll_ch.valid = 1'b0;
    poll_ch.tick  = '0;
    poll_ch.pins  = '1;
    reg_ch.valid  = 1'b0;
    reg_ch.index  = REG_DEBOUNCE;
    reg_ch.data   = '0;
    scan_ch.ready = 1'b0;
    src_idle_pct  = 9;
    snk_idle_pct  = 9;
    mismatches    = 0;
    stall_cycles  = 0;
    thr.settle_ticks      = 16'd20;
    thr.hold_ticks        = 16'd1000;
    thr.repeat_start_time = 16'd500;
    thr.repeat_interval   = 16'd100;
    key_count             = 5'd8;
    for (int k = 0; k < NUM_KEYS; k++) begin
      lane_mode[k] = MODE_RELEASE;
      lane_mark[k] = '0;
      lane_rpt[k]  = '0;
    end

    plan = '{
      check_row(32'd0, 16'hFFFF, EV_NONE, 4'd0),
      check_row(32'd0, 16'hFFFE, EV_NONE, 4'd0),
      check_row(32'd19, 16'hFFFE, EV_NONE, 4'd0),
      check_row(32'd20, 16'hFFFE, EV_PRESS, 4'd0),
      check_row(32'd1020, 16'hFFFE, EV_LONG, 4'd0),
      check_row(32'd1520, 16'hFFFE, EV_NONE, 4'd0),
      check_row(32'd1620, 16'hFFFE, EV_REPEAT, 4'd0),
      check_row(32'd1620, 16'hFFFF, EV_NONE, 4'd0),
      check_row(32'd2000, 16'hFFFC, EV_NONE, 4'd0),
      check_row(32'd2020, 16'hFFFC, EV_PRESS, 4'd0),
      check_row(32'd2021, 16'hFFFC, EV_PRESS, 4'd1),
      check_row(32'd2022, 16'hFFFF, EV_RELEASE, 4'd0),
      check_row(32'd2023, 16'hFFFF, EV_RELEASE, 4'd1),
      check_row(32'hFFFF_FFF0, 16'hFF7F, EV_NONE, 4'd0),
      check_row(32'h0000_0004, 16'hFF7F, EV_PRESS, 4'd7),
      check_row(32'd1004, 16'hFF7F, EV_LONG, 4'd7),
      check_row(32'd1005, 16'hFFFF, EV_LONG_RELEASE, 4'd7),
      check_row(32'd5000, 16'h0000, EV_NONE, 4'd0),
      check_row(32'd5020, 16'h0000, EV_PRESS, 4'd0),
      write_row(REG_KEY_COUNT, 16'h0000),
      check_row(32'd6000, 16'h0000, EV_NONE, 4'd0),
      check_row(32'hFFFF_FFFF, 16'hFFFF, EV_NONE, 4'd0),
      write_row(REG_KEY_COUNT, 16'hFFF1),
      poll_row(32'd8000, 16'h7FFF),
      poll_row(32'd8001, 16'h7FFF),
      poll_row(32'd8002, 16'h7FFF),
      write_row(REG_DEBOUNCE, 16'h0000),
      write_row(REG_LONG_PRESS, 16'h0000),
      write_row(REG_REPEAT_START, 16'h0000),
      write_row(REG_REPEAT_INTV, 16'h0000),
      poll_row(32'd8002, 16'h7FFF),
      poll_row(32'd8002, 16'h7FFF),
      poll_row(32'd8002, 16'h7FFF),
      poll_row(32'd8002, 16'h7FFF)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].reg_sel, plan[i].data);
      end else begin
        send_poll(plan[i].tick, plan[i].pins, plan[i].typed, plan[i].res);
      end
    end

    // Phase p == 3 runs with the source never idling and the sink always ready.
    for (int p = 0; p < 7; p++) begin
      src_idle_pct = (p == 3) ? 0 : 9;
      snk_idle_pct = src_idle_pct;
      run_phase((p == 1) ? PH_ZERO : (p == 5) ? PH_MAX : PH_RANDOM, 84);
    end

    wait_drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
